// ===== hw/rtl/wrt_pkg.sv =====
// wrt_pkg: shared types and constants for the window rank transform
// no dependencies; used by wrt_cell, window_rank_transform and wrt_checker
package wrt_pkg;

  // default sizes
  localparam int MAX_SIDE_DEF   = 7;
  localparam int VALUE_BITS_DEF = 16;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int RANK_W     = 6;
  localparam int SIDE_W     = 3;
  localparam int THR_W      = 6;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_THRESHOLD = 2'd1;

  // legal window sides
  localparam logic [SIDE_W-1:0] SIDE_3 = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_5 = 3'd5;
  localparam logic [SIDE_W-1:0] SIDE_7 = 3'd7;
  localparam int SIDE_RESET = 3;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_LOAD,
    ST_RANK,
    ST_FIN,
    ST_OUT
  } wrt_state_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic load;    // sample beat accepted, cell at fill index captures it
    logic init;    // copy own sample into the circulating register, clear counts
    logic cmp;     // compare and rotate the ring
    logic fin;     // fold counts into a rank
    logic drain;   // shift ranks one cell towards the head
  } wrt_cell_ctl_t;

endpackage

// ===== hw/rtl/wrt_cell.sv =====
// wrt_cell: one element of the ranking chain, holds a sample, its counts and rank
// depends on wrt_pkg (wrt_cell_ctl_t)
module wrt_cell #(
  parameter int IDX   = 0,
  parameter int SW    = 16,
  parameter int CNT_W = 6,
  parameter int IDX_W = 6
) (
  input  logic                   clk,
  input  wrt_pkg::wrt_cell_ctl_t ctl,
  input  logic [IDX_W-1:0]       cur_idx,
  input  logic [IDX_W-1:0]       last_idx,
  input  logic [SW-1:0]          sample,
  input  logic [SW-1:0]          circ_next,
  input  logic [SW-1:0]          circ_head,
  input  logic [CNT_W-1:0]       rank_next,
  output logic [SW-1:0]          circ,
  output logic [CNT_W-1:0]       rank
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [SW-1:0]      own_r;
  logic [SW-1:0]      circ_r;
  logic [CNT_W-1:0]   less_r;
  logic [CNT_W-1:0]   eq_r;
  logic [CNT_W-1:0]   rank_r;
  logic [CNT_W+1:0]   rank_sum;

  // floor((2*less + equal + 1) / 2)
  assign rank_sum = {1'b0, less_r, 1'b0} + {2'b00, eq_r} + (CNT_W+2)'(1);

  always_ff @(posedge clk) begin
    if (ctl.load && cur_idx == MY_IDX) begin
      own_r <= sample;
    end
    if (ctl.init) begin
      circ_r <= own_r;
      less_r <= '0;
      eq_r   <= '0;
    end else if (ctl.cmp) begin
      // ring closes at the last active cell
      circ_r <= (last_idx == MY_IDX) ? circ_head : circ_next;
      if (circ_r < own_r) begin
        less_r <= less_r + CNT_W'(1);
      end
      if (circ_r == own_r) begin
        eq_r <= eq_r + CNT_W'(1);
      end
    end
    if (ctl.fin) begin
      rank_r <= rank_sum[CNT_W:1];
    end else if (ctl.drain) begin
      rank_r <= rank_next;
    end
  end

  assign circ = circ_r;
  assign rank = rank_r;

endmodule

// ===== hw/rtl/window_rank_transform.sv =====
// window_rank_transform: tie-averaged rank of every element of a square window
// depends on wrt_pkg and wrt_cell
//
//  beat        | ports                                   | dir | moves
//  ------------+-----------------------------------------+-----+---------------------------
//  sample      | in_valid / in_ready / in_sample_value   | in  | one window element
//  rank        | out_valid / out_ready / out_rank_value, | out | one element's rank, edge
//              |   out_edge_flag, out_last_of_window     |     |   flag and end marker
//  config      | cfg_wr_en / cfg_index / cfg_wdata       | in  | register write, no wait
//
// a window of n = side*side samples is filled at one sample beat a cycle while in_valid is high,
// then the ring is seeded, the ring carries every sample past every cell, the counts are folded
// into ranks and the n ranks stream out
// sample beats are taken only while filling; an output stall freezes the rank chain
// reset (synchronous, active low) empties the window, side 3 and threshold 0
// a legal side write restarts the count of the current phase, so a partial fill starts over
module window_rank_transform #(
  parameter int MAX_SIDE   = wrt_pkg::MAX_SIDE_DEF,
  parameter int VALUE_BITS = wrt_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wrt_pkg::SAMPLE_W-1:0]   in_sample_value,
  // rank beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wrt_pkg::RANK_W-1:0]     out_rank_value,
  output logic                           out_edge_flag,
  output logic                           out_last_of_window,
  // register writes
  input  logic                           cfg_wr_en,
  input  logic [wrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrt_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  // only the low bits of the sample field take part
  localparam int SW    = (VALUE_BITS < wrt_pkg::SAMPLE_W) ? VALUE_BITS : wrt_pkg::SAMPLE_W;

  wrt_pkg::wrt_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            n_r, n_nxt;
  logic [wrt_pkg::THR_W-1:0]   thr_r, thr_nxt;
  wrt_pkg::wrt_cell_ctl_t      ctl;

  logic [wrt_pkg::SIDE_W-1:0]  side_wr;
  logic                        side_ok;
  logic                        at_last;
  logic [IDX_W-1:0]            last_idx;

  logic [SW-1:0]               circ_w [DEPTH];
  logic [CNT_W-1:0]            rank_w [DEPTH];

  assign last_idx = IDX_W'(n_r - CNT_W'(1));
  assign at_last  = (cnt_r == n_r - CNT_W'(1));

  // side register: only 3, 5 or 7 that fit the chain are taken
  assign side_wr = cfg_wdata[wrt_pkg::SIDE_W-1:0];
  assign side_ok = (side_wr == wrt_pkg::SIDE_3 || side_wr == wrt_pkg::SIDE_5 ||
                    side_wr == wrt_pkg::SIDE_7) && (int'(side_wr) <= MAX_SIDE);

  always_comb begin
    n_nxt   = n_r;
    thr_nxt = thr_r;
    if (cfg_wr_en && cfg_index == wrt_pkg::REG_WINDOW_SIDE && side_ok) begin
      case (side_wr)
        wrt_pkg::SIDE_3: n_nxt = CNT_W'(9);
        wrt_pkg::SIDE_5: n_nxt = CNT_W'(25);
        wrt_pkg::SIDE_7: n_nxt = CNT_W'(49);
        default:         n_nxt = n_r;
      endcase
    end
    if (cfg_wr_en && cfg_index == wrt_pkg::REG_RANK_THRESHOLD) begin
      thr_nxt = cfg_wdata[wrt_pkg::THR_W-1:0];
    end
  end

  // sequencer: fill, seed ring, rotate, fold, drain
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      wrt_pkg::ST_FILL: begin
        // ready is high throughout filling, so valid alone marks the beat
        in_ready = 1'b1;
        ctl.load = in_valid;
        if (in_valid) begin
          if (at_last) begin
            cnt_nxt   = '0;
            state_nxt = wrt_pkg::ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      wrt_pkg::ST_LOAD: begin
        ctl.init  = 1'b1;
        state_nxt = wrt_pkg::ST_RANK;
      end
      wrt_pkg::ST_RANK: begin
        ctl.cmp = 1'b1;
        if (at_last) begin
          cnt_nxt   = '0;
          state_nxt = wrt_pkg::ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      wrt_pkg::ST_FIN: begin
        ctl.fin   = 1'b1;
        state_nxt = wrt_pkg::ST_OUT;
      end
      wrt_pkg::ST_OUT: begin
        // valid is high throughout draining, so ready alone marks the beat
        out_valid = 1'b1;
        ctl.drain = out_ready;
        if (out_ready) begin
          if (at_last) begin
            cnt_nxt   = '0;
            state_nxt = wrt_pkg::ST_FILL;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = wrt_pkg::ST_FILL;
        cnt_nxt   = '0;
      end
    endcase
    // a legal side write restarts the count of the current phase
    if (cfg_wr_en && cfg_index == wrt_pkg::REG_WINDOW_SIDE && side_ok) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrt_pkg::ST_FILL;
      cnt_r   <= '0;
      n_r     <= CNT_W'(wrt_pkg::SIDE_RESET * wrt_pkg::SIDE_RESET);
      thr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      thr_r   <= thr_nxt;
    end
  end

  // the chain: cell k owns element k, the ring shifts towards cell 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [CNT_W-1:0] rank_in;
    if (k == DEPTH - 1) begin : g_tail
      assign rank_in = '0;
    end else begin : g_body
      assign rank_in = rank_w[k+1];
    end
    wrt_cell #(
      .IDX   (k),
      .SW    (SW),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cur_idx   (cnt_r[IDX_W-1:0]),
      .last_idx  (last_idx),
      .sample    (in_sample_value[SW-1:0]),
      .circ_next (circ_w[(k+1) % DEPTH]),
      .circ_head (circ_w[0]),
      .rank_next (rank_in),
      .circ      (circ_w[k]),
      .rank      (rank_w[k])
    );
  end

  // head of the rank chain is the output beat
  assign out_rank_value     = wrt_pkg::RANK_W'(rank_w[0]);
  assign out_edge_flag      = (wrt_pkg::RANK_W'(rank_w[0]) > thr_r);
  assign out_last_of_window = out_valid && at_last;

endmodule

// ===== hw/rtl/wrt_checker.sv =====
// wrt_checker: port-level checks on window_rank_transform, bound to the top level
// depends on wrt_pkg and window_rank_transform
module wrt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wrt_pkg::RANK_W-1:0]    out_rank_value,
  input logic                          out_last_of_window
);

  // a stalled rank beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank_value))
    else $error("rank beat changed while stalled");

  // no sample taken while ranks are draining
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid))
    else $error("sample beat taken while ranks draining");

  // ranks are 1-based
  a_rank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rank_value != '0)
    else $error("rank of zero");

  // window ends after its last rank beat
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_window |=> !out_valid)
    else $error("rank beat after end of window");

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("rank beat straight after reset");

endmodule

bind window_rank_transform wrt_checker u_wrt_checker (.*);
